FILE: hw/rtl/tgr_pkg.sv
// Shared types, screen constants and the 5x7 font for the text glyph rectangle generator.
`timescale 1ns / 1ps
`default_nettype none

package tgr_pkg;

    // Screen size in pixels.
    localparam int SCREEN_WIDTH  = 480;
    localparam int SCREEN_HEIGHT = 320;

    // Glyph geometry: five columns of seven rows, one bit per pixel.
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;

    // Special text bytes.
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] CFG_SCALE    = 2'd2;
    localparam logic [1:0] CFG_COLOR    = 2'd3;

    // Configuration as seen by the front and back parts.
    typedef struct packed {
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [7:0]  glyph_scale;
        logic [15:0] draw_color;
    } t_cfg;

    // One draw command: glyph bits (column-major) and the top-left cursor position.
    typedef struct packed {
        logic [GLYPH_BITS-1:0] glyph;
        logic [15:0]           col;
        logic [15:0]           row;
    } t_cmd;

    // One rectangle before its color and last mark are attached.
    typedef struct packed {
        logic [7:0] h;
        logic [7:0] w;
        logic [8:0] y;
        logic [8:0] x;
    } t_rect;

    // A scale of zero counts as one.
    function automatic logic [7:0] eff_scale(input logic [7:0] scale);
        return (scale == 8'd0) ? 8'd1 : scale;
    endfunction

    // Pack five font columns so that bit (col * 7 + row) is the pixel.
    function automatic logic [GLYPH_BITS-1:0] pack_cols(
        input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
        input logic [7:0] c3, input logic [7:0] c4);
        return {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
    endfunction

    // Font lookup with lower case folded to upper case; unknown codes are blank.
    function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
        logic [7:0]            key;
        logic [GLYPH_BITS-1:0] g;
        key = code;
        if (code >= 8'h61 && code <= 8'h7A) begin
            key = code - 8'h20;
        end
        unique case (key)
            8'h41:   g = pack_cols(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
            8'h42:   g = pack_cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h43:   g = pack_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
            8'h44:   g = pack_cols(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
            8'h45:   g = pack_cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
            8'h46:   g = pack_cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
            8'h47:   g = pack_cols(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
            8'h48:   g = pack_cols(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
            8'h49:   g = pack_cols(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
            8'h4A:   g = pack_cols(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
            8'h4B:   g = pack_cols(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
            8'h4C:   g = pack_cols(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
            8'h4D:   g = pack_cols(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
            8'h4E:   g = pack_cols(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
            8'h4F:   g = pack_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
            8'h50:   g = pack_cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
            8'h51:   g = pack_cols(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
            8'h52:   g = pack_cols(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
            8'h53:   g = pack_cols(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
            8'h54:   g = pack_cols(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
            8'h55:   g = pack_cols(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
            8'h56:   g = pack_cols(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
            8'h57:   g = pack_cols(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
            8'h58:   g = pack_cols(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
            8'h59:   g = pack_cols(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
            8'h5A:   g = pack_cols(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
            8'h30:   g = pack_cols(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
            8'h31:   g = pack_cols(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
            8'h32:   g = pack_cols(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
            8'h33:   g = pack_cols(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
            8'h34:   g = pack_cols(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
            8'h35:   g = pack_cols(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
            8'h36:   g = pack_cols(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
            8'h37:   g = pack_cols(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
            8'h38:   g = pack_cols(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h39:   g = pack_cols(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
            8'h2D:   g = pack_cols(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
            8'h21:   g = pack_cols(8'h00, 8'h00, 8'h5F, 8'h00, 8'h00);
            8'h3A:   g = pack_cols(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
            8'h2E:   g = pack_cols(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tgr_front.sv
// Front part: accepts text bytes, keeps the cursor and issues draw commands.
`timescale 1ns / 1ps
`default_nettype none

module tgr_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire tgr_pkg::t_cfg   i_cfg,
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    input  wire [7:0]            i_s_tdata,   // char_code [7:0]
    input  wire                  i_s_tuser,   // string_start
    input  wire                  i_cmd_full,
    output logic                 o_cmd_push,
    output tgr_pkg::t_cmd        o_cmd
);
    import tgr_pkg::*;

    logic [15:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic        r_halt, n_halt;

    logic [7:0]            s;
    logic [10:0]           s5, s6, s7, s8;
    logic [15:0]           col0, row0, col1, row1;
    logic                  halt0;
    logic                  accept;
    logic [GLYPH_BITS-1:0] glyph;

    // Any byte may need a queue slot, so accept only while the queue has room.
    assign o_s_tready = !i_cmd_full;
    assign accept     = i_s_tvalid && o_s_tready;

    // Multiples of the scale used by the cursor tests and steps.
    assign s  = eff_scale(i_cfg.glyph_scale);
    assign s8 = {s, 3'b000};
    assign s7 = s8 - {3'b000, s};
    assign s5 = {1'b0, s, 2'b00} + {3'b000, s};
    assign s6 = {1'b0, s, 2'b00} + {2'b00, s, 1'b0};

    assign glyph = glyph_bits(i_s_tdata);

    // Cursor handling for one byte.
    always_comb begin
        col0 = i_s_tuser ? i_cfg.origin_x : r_col;
        row0 = i_s_tuser ? i_cfg.origin_y : r_row;
        halt0 = i_s_tuser ? 1'b0 : r_halt;
        col1 = col0;
        row1 = row0;
        n_col = col0;
        n_row = row0;
        n_halt = halt0;
        o_cmd_push = 1'b0;
        if (halt0) begin
            n_halt = 1'b1;
        end else if (i_s_tdata == CHAR_NUL) begin
            n_halt = 1'b1;
        end else if (i_s_tdata == CHAR_NEWLINE) begin
            n_col = i_cfg.origin_x;
            n_row = row0 + {5'd0, s8};
        end else if (({1'b0, row0} + {6'd0, s7}) >= 17'(SCREEN_HEIGHT)) begin
            n_halt = 1'b1;
        end else begin
            // Wrap to a new line when the glyph would reach the right edge.
            if (({1'b0, col0} + {6'd0, s5}) >= 17'(SCREEN_WIDTH)) begin
                col1 = i_cfg.origin_x;
                row1 = row0 + {5'd0, s8};
            end
            n_col = col1 + {5'd0, s6};
            n_row = row1;
            o_cmd_push = accept && (glyph != '0);
        end
    end

    assign o_cmd.glyph = glyph;
    assign o_cmd.col   = col1;
    assign o_cmd.row   = row1;

    // Cursor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_halt <= 1'b0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_halt <= n_halt;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tgr_cmd_fifo.sv
// Two-entry command queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module tgr_cmd_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire tgr_pkg::t_cmd   i_cmd,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_valid,
    output tgr_pkg::t_cmd        o_cmd
);
    import tgr_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // The queue never overflows or underflows.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("command queue underflow");

endmodule

`default_nettype wire

FILE: hw/rtl/tgr_back.sv
// Back part: scans glyph bits and emits clipped rectangles, marking the last one.
`timescale 1ns / 1ps
`default_nettype none

module tgr_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire tgr_pkg::t_cfg   i_cfg,
    input  wire                  i_cmd_valid,
    input  wire tgr_pkg::t_cmd   i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    output logic [55:0]          o_m_tdata,   // rect_x [8:0], rect_y [17:9], rect_w [25:18],
                                              // rect_h [33:26], rect_color [49:34], zeros
    output logic                 o_m_tlast    // last_rect
);
    import tgr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state                r_state;
    logic [GLYPH_BITS-1:0] r_glyph;
    logic [15:0]           r_col;
    logic [15:0]           r_row;
    logic [2:0]            r_r;
    logic [2:0]            r_c;
    logic [9:0]            r_xoff;
    logic [10:0]           r_yoff;
    logic                  r_pend_v;
    t_rect                 r_pend;
    logic                  r_out_v;
    t_rect                 r_out;
    logic [15:0]           r_out_color;
    logic                  r_out_last;

    logic [7:0]  s;
    logic [15:0] cx, cy;
    logic        cand_emit;
    t_rect       cand;
    logic        out_free;
    logic        advance;
    logic        rest_zero;
    logic        out_load;

    assign s = eff_scale(i_cfg.glyph_scale);

    // Candidate square for the current glyph bit.
    always_comb begin
        cx = r_col + {6'd0, r_xoff};
        cy = r_row + {5'd0, r_yoff};
        cand_emit = r_glyph[0] && (cx < 16'(SCREEN_WIDTH)) && (cy < 16'(SCREEN_HEIGHT));
        cand.x = cx[8:0];
        cand.y = cy[8:0];
        cand.w = s;
        cand.h = s;
        if (({1'b0, cx} + {9'd0, s}) > 17'(SCREEN_WIDTH)) begin
            cand.w = 8'(17'(SCREEN_WIDTH) - {1'b0, cx});
        end
        if (({1'b0, cy} + {9'd0, s}) > 17'(SCREEN_HEIGHT)) begin
            cand.h = 8'(17'(SCREEN_HEIGHT) - {1'b0, cy});
        end
    end

    // The output register is free when empty or being taken this cycle.
    assign out_free  = !r_out_v || i_m_tready;
    assign advance   = !(cand_emit && r_pend_v && !out_free);
    assign rest_zero = (r_glyph[GLYPH_BITS-1:1] == '0);
    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;

    // The output register is loaded by a new square in the scan or by the flush.
    assign out_load = ((r_state == ST_SCAN) && advance && cand_emit && r_pend_v) ||
                      ((r_state == ST_FLUSH) && r_pend_v && out_free);

    // Scan sequencer, pending rectangle and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_m_tready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_glyph <= i_cmd.glyph;
                        r_col   <= i_cmd.col;
                        r_row   <= i_cmd.row;
                        r_r     <= '0;
                        r_c     <= '0;
                        r_xoff  <= '0;
                        r_yoff  <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (advance) begin
                        // A new square pushes the held one out as not last.
                        if (cand_emit) begin
                            if (r_pend_v) begin
                                r_out       <= r_pend;
                                r_out_color <= i_cfg.draw_color;
                                r_out_last  <= 1'b0;
                            end
                            r_pend   <= cand;
                            r_pend_v <= 1'b1;
                        end
                        r_glyph <= r_glyph >> 1;
                        if (r_r == 3'(GLYPH_ROWS - 1)) begin
                            r_r    <= '0;
                            r_yoff <= '0;
                            r_c    <= r_c + 3'd1;
                            r_xoff <= r_xoff + {2'b00, s};
                        end else begin
                            r_r    <= r_r + 3'd1;
                            r_yoff <= r_yoff + {3'b000, s};
                        end
                        if (rest_zero) begin
                            r_state <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    // The held square is the last of this character.
                    if (!r_pend_v) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_out       <= r_pend;
                        r_out_color <= i_cfg.draw_color;
                        r_out_last  <= 1'b1;
                        r_pend_v    <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {6'd0, r_out_color, r_out.h, r_out.w, r_out.y, r_out.x};
    assign o_m_tlast  = r_out_last;

    // No square is held over from one character to the next.
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v)
        else $error("pending rectangle left at character end");

    // The scan position stays inside the glyph.
    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_r < 3'(GLYPH_ROWS) && r_c < 3'(GLYPH_COLS)))
        else $error("glyph scan position out of range");

    // A full output register is never overwritten while it waits.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_m_tready) |=> (r_out_v && $stable(o_m_tdata)))
        else $error("output rectangle overwritten while stalled");

endmodule

`default_nettype wire

FILE: hw/rtl/text_glyph_rect_generator_top.sv
// Top level of the text glyph rectangle generator: configuration registers and wiring.
// An accepted byte passes as a command through the queue, the scan registers, the pending
// rectangle and the output register. Up to one rectangle per cycle while the output is not
// stalled. A character holds the bit-serial scan up to its last set glyph bit; the next one
// is taken after its flush. Control bytes and blank glyphs never reach the scan.
// Reset (synchronous, active low) clears the cursor, the halt flag, the command queue and
// the output, and loads the configuration defaults: origin 0,0, scale 1, color white.
`timescale 1ns / 1ps
`default_nettype none

module text_glyph_rect_generator_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [1:0]   i_cfg_addr,
    input  wire [15:0]  i_cfg_data,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire [7:0]   i_s_tdata,   // char_code [7:0]
    input  wire         i_s_tuser,   // string_start
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [55:0] o_m_tdata,   // rect_x [8:0], rect_y [17:9], rect_w [25:18],
                                     // rect_h [33:26], rect_color [49:34], zeros
    output logic        o_m_tlast    // last_rect
);
    import tgr_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd;
    t_cmd pop_cmd;
    logic cmd_push;
    logic cmd_pop;
    logic cmd_full;
    logic cmd_valid;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x    <= '0;
            r_cfg.origin_y    <= '0;
            r_cfg.glyph_scale <= 8'd1;
            r_cfg.draw_color  <= 16'hFFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_ORIGIN_X: r_cfg.origin_x    <= i_cfg_data;
                CFG_ORIGIN_Y: r_cfg.origin_y    <= i_cfg_data;
                CFG_SCALE:    r_cfg.glyph_scale <= i_cfg_data[7:0];
                CFG_COLOR:    r_cfg.draw_color  <= i_cfg_data;
                default:      r_cfg.draw_color  <= r_cfg.draw_color;
            endcase
        end
    end

    tgr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (push_cmd)
    );

    tgr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (push_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (pop_cmd)
    );

    tgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (pop_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

`default_nettype wire

FILE: sim/tb_text_glyph_rect_generator_top.sv
// Self-checking testbench for the text glyph rectangle generator top level.
`timescale 1ns / 1ps

module tb_text_glyph_rect_generator_top;
    import tgr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int MAX_REPORTS    = 10;
    localparam int MAX_WAIT       = 12;

    // One rectangle as it leaves the block.
    typedef struct packed {
        logic [8:0]  x;
        logic [8:0]  y;
        logic [7:0]  w;
        logic [7:0]  h;
        logic [15:0] color;
        logic        last;
    } rect_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_addr  = '0;
    logic [15:0] i_cfg_data  = '0;
    logic        i_s_tvalid  = 1'b0;
    logic [7:0]  i_s_tdata   = '0;
    logic        i_s_tuser   = 1'b0;
    logic        i_m_tready  = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [55:0] o_m_tdata;
    logic        o_m_tlast;

    // Shadow of the configuration registers and of the text cursor.
    logic [15:0] org_x      = 16'd0;
    logic [15:0] org_y      = 16'd0;
    logic [7:0]  scale      = 8'd1;
    logic [15:0] draw_color = 16'hFFFF;
    logic [15:0] cur_col    = 16'd0;
    logic [15:0] cur_row    = 16'd0;
    logic        text_halted = 1'b0;

    rect_t pending_rects[$];
    int    errors  = 0;
    int    m_stall = 0;
    bit    s_burst = 1'b0;
    bit    m_burst = 1'b0;

    always #5 i_clk = ~i_clk;

    text_glyph_rect_generator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    // Font columns, first column in the top byte; bit 0 of a column is the top row.
    function automatic logic [39:0] font_cols(input logic [7:0] code);
        logic [7:0] key;
        key = code;
        if (code >= "a" && code <= "z") begin
            key = code - 8'd32;
        end
        case (key)
            "A": return {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
            "B": return {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
            "C": return {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
            "D": return {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
            "E": return {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
            "F": return {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
            "G": return {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
            "H": return {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
            "I": return {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
            "J": return {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
            "K": return {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
            "L": return {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
            "M": return {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
            "N": return {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
            "O": return {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
            "P": return {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
            "Q": return {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
            "R": return {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
            "S": return {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
            "T": return {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
            "U": return {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
            "V": return {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
            "W": return {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
            "X": return {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
            "Y": return {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
            "Z": return {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
            "0": return {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
            "1": return {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
            "2": return {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
            "3": return {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
            "4": return {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
            "5": return {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
            "6": return {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
            "7": return {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
            "8": return {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            "9": return {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
            "-": return {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
            "!": return {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
            ":": return {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
            ".": return {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
            default: return '0;
        endcase
    endfunction

    // Apply one text byte to the cursor and queue the rectangles it must produce.
    function automatic void draw_char(input logic [7:0] code, input logic start);
        int          s;
        int          x;
        int          y;
        int          w;
        int          h;
        logic [39:0] cols;
        logic [7:0]  col_bits;
        rect_t       held;
        bit          have_held;
        s         = (scale == 8'd0) ? 1 : int'(scale);
        held      = '0;
        have_held = 1'b0;
        if (start) begin
            cur_col     = org_x;
            cur_row     = org_y;
            text_halted = 1'b0;
        end
        if (text_halted) return;
        if (code == CHAR_NUL) begin
            text_halted = 1'b1;
            return;
        end
        if (code == CHAR_NEWLINE) begin
            cur_col = org_x;
            cur_row = 16'(int'(cur_row) + 8 * s);
            return;
        end
        // The bottom test uses the exact sum; the right-edge wrap does not retest it.
        if (int'(cur_row) + 7 * s >= SCREEN_HEIGHT) begin
            text_halted = 1'b1;
            return;
        end
        if (int'(cur_col) + 5 * s >= SCREEN_WIDTH) begin
            cur_col = org_x;
            cur_row = 16'(int'(cur_row) + 8 * s);
        end
        cols = font_cols(code);
        for (int c = 0; c < 5; c++) begin
            col_bits = cols[39 - 8 * c -: 8];
            for (int r = 0; r < 7; r++) begin
                if (!col_bits[r]) continue;
                x = (int'(cur_col) + c * s) & 'hFFFF;
                y = (int'(cur_row) + r * s) & 'hFFFF;
                if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) continue;
                w = (x + s > SCREEN_WIDTH) ? SCREEN_WIDTH - x : s;
                h = (y + s > SCREEN_HEIGHT) ? SCREEN_HEIGHT - y : s;
                // Hold each square back by one so the final one can be marked last.
                if (have_held) pending_rects.push_back(held);
                held.x     = 9'(x);
                held.y     = 9'(y);
                held.w     = 8'(w);
                held.h     = 8'(h);
                held.color = draw_color;
                held.last  = 1'b0;
                have_held  = 1'b1;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            pending_rects.push_back(held);
        end
        cur_col = 16'(int'(cur_col) + 6 * s);
    endfunction

    function automatic string rect_text(input rect_t r);
        return $sformatf("x=%0d y=%0d w=%0d h=%0d color=%h last=%b",
                         r.x, r.y, r.w, r.h, r.color, r.last);
    endfunction

    // Send one text byte; entered and left at a falling edge.
    task automatic send_char(input logic [7:0] code, input logic start);
        int gap;
        gap = s_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 15) == 0) s_burst = !s_burst;
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = code;
        i_s_tuser  = start;
        do @(posedge i_clk); while (!o_s_tready);
        draw_char(code, start);
        @(negedge i_clk);
    endtask

    // Let every queued rectangle arrive and any silent scan finish.
    // Up to three queued characters may scan without a visible word.
    task automatic wait_idle();
        i_s_tvalid = 1'b0;
        while (pending_rects.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [15:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (addr)
            CFG_ORIGIN_X: org_x      = data;
            CFG_ORIGIN_Y: org_y      = data;
            CFG_SCALE:    scale      = data[7:0];
            CFG_COLOR:    draw_color = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [15:0] ox, input logic [15:0] oy,
                              input logic [7:0] sc, input logic [15:0] color);
        wait_idle();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_SCALE, {8'd0, sc});
        write_reg(CFG_COLOR, color);
    endtask

    // Reset configuration: case folding, blank and unknown codes, newline, NUL and halt.
    task automatic test_defaults_and_controls();
        send_char("A", 1'b1);
        send_char("b", 1'b0);
        send_char(" ", 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(CHAR_NEWLINE, 1'b0);
        send_char(".", 1'b0);
        send_char(CHAR_NUL, 1'b0);
        send_char("X", 1'b0);
        send_char(CHAR_NEWLINE, 1'b0);
    endtask

    // Wrap at the right edge, clipping on both edges, then a halt at the bottom.
    task automatic test_right_edge_clip();
        set_config(16'd460, 16'd271, 8'd5, 16'h0000);
        send_char("M", 1'b1);
        send_char("W", 1'b0);
        send_char(CHAR_NEWLINE, 1'b1);
        send_char("8", 1'b0);
    endtask

    // Cursor sums that wrap past 65535, and a zero scale.
    task automatic test_cursor_wrap();
        set_config(16'hFFFA, 16'd0, 8'd0, 16'hFFFF);
        send_char("A", 1'b1);
        send_char("Z", 1'b0);
        set_config(16'd0, 16'hFFFA, 8'd1, 16'hA5C3);
        send_char("A", 1'b1);
    endtask

    // Large squares, a wrap that lands fully off screen, and the largest scale.
    task automatic test_large_scale();
        set_config(16'd0, 16'd0, 8'd45, 16'h5A3C);
        send_char("H", 1'b1);
        send_char("4", 1'b0);
        set_config(16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF);
        send_char("A", 1'b1);
        send_char(CHAR_NEWLINE, 1'b0);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return "A" + 8'($urandom_range(0, 25));
        if (r < 60) return "a" + 8'($urandom_range(0, 25));
        if (r < 70) return "0" + 8'($urandom_range(0, 9));
        if (r < 78) begin
            case ($urandom_range(0, 4))
                0: return " ";
                1: return "-";
                2: return "!";
                3: return ":";
                default: return ".";
            endcase
        end
        if (r < 86) return CHAR_NEWLINE;
        if (r < 97) return 8'($urandom_range(0, 255));
        return CHAR_NUL;
    endfunction

    task automatic random_config();
        logic [15:0] ox;
        logic [15:0] oy;
        logic [7:0]  sc;
        case ($urandom_range(0, 9))
            0: ox = 16'($urandom);
            1: ox = 16'($urandom_range(400, 479));
            default: ox = 16'($urandom_range(0, 300));
        endcase
        case ($urandom_range(0, 9))
            0: oy = 16'($urandom);
            1: oy = 16'($urandom_range(200, 319));
            default: oy = 16'($urandom_range(0, 150));
        endcase
        case ($urandom_range(0, 11))
            0: sc = 8'd0;
            1: sc = 8'd255;
            2, 3: sc = 8'($urandom_range(5, 45));
            default: sc = 8'($urandom_range(1, 4));
        endcase
        set_config(ox, oy, sc, 16'($urandom));
    endtask

    // Mostly strings opened by a string start, with stray starts and missing ones mixed in.
    task automatic test_random_text(input int n_items);
        int         sent;
        int         left;
        int         len;
        logic [7:0] code;
        logic       start;
        sent = 0;
        while (sent < n_items) begin
            random_config();
            left = $urandom_range(25, 55);
            while (left > 0 && sent < n_items) begin
                len = $urandom_range(3, 24);
                for (int i = 0; i < len && left > 0; i++) begin
                    code  = pick_char();
                    start = (i == 0) ? ($urandom_range(0, 14) != 0)
                                     : ($urandom_range(0, 24) == 0);
                    send_char(code, start);
                    sent++;
                    left--;
                    if (code == CHAR_NUL) break;
                end
            end
        end
    endtask

    // Output-side stall: a fresh wait count is drawn for every word taken.
    always @(negedge i_clk) begin
        if (m_stall > 0) begin
            i_m_tready = 1'b0;
            m_stall    = m_stall - 1;
        end else begin
            i_m_tready = 1'b1;
        end
    end

    // Compare each rectangle word with the oldest prediction.
    always @(posedge i_clk) begin : rect_check
        rect_t got;
        rect_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.x     = o_m_tdata[8:0];
            got.y     = o_m_tdata[17:9];
            got.w     = o_m_tdata[25:18];
            got.h     = o_m_tdata[33:26];
            got.color = o_m_tdata[49:34];
            got.last  = o_m_tlast;
            if (pending_rects.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected rectangle: %s", rect_text(got));
            end else begin
                want = pending_rects.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
                    got.h !== want.h || got.color !== want.color ||
                    got.last !== want.last) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("rectangle mismatch: expected %s, got %s",
                                 rect_text(want), rect_text(got));
                end
            end
            m_stall = m_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 19) == 0) m_burst = !m_burst;
        end
    end

    // End the run when no word has moved on any channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_defaults_and_controls();
        test_right_edge_clip();
        test_cursor_wrap();
        test_large_scale();
        test_random_text(430);
        wait_idle();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
